/* rtl/amux_pkg.sv */
// ----------------------------------------------------------------------------
// amux_pkg
// Shared types and constants of the AVI MJPEG muxer.
// ----------------------------------------------------------------------------
package amux_pkg;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_MOVI  = 2'd1,
        PH_FRAME = 2'd2,
        PH_INDEX = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        MODE_START   = 3'd0,
        MODE_FBEGIN  = 3'd1,
        MODE_FBYTE   = 3'd2,
        MODE_IBEGIN  = 3'd3,
        MODE_INEXT   = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        REG_WIDTH  = 3'd0,
        REG_HEIGHT = 3'd1,
        REG_FPS    = 3'd2,
        REG_TOTAL  = 3'd3,
        REG_FIRST  = 3'd4
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_HDR   = 3'd1,
        ST_SEQ   = 3'd2,
        ST_IDXRD = 3'd3,
        ST_DIV   = 3'd4
    } t_state;

    localparam logic [31:0] FCC_RIFF = 32'h46464952;
    localparam logic [31:0] FCC_AVI  = 32'h20495641;
    localparam logic [31:0] FCC_LIST = 32'h5453494C;
    localparam logic [31:0] FCC_HDRL = 32'h6C726468;
    localparam logic [31:0] FCC_AVIH = 32'h68697661;
    localparam logic [31:0] FCC_STRL = 32'h6C727473;
    localparam logic [31:0] FCC_STRH = 32'h68727473;
    localparam logic [31:0] FCC_VIDS = 32'h73646976;
    localparam logic [31:0] FCC_MJPG = 32'h47504A4D;
    localparam logic [31:0] FCC_STRF = 32'h66727473;
    localparam logic [31:0] FCC_ODML = 32'h6C6D646F;
    localparam logic [31:0] FCC_DMLH = 32'h686C6D64;
    localparam logic [31:0] FCC_MOVI = 32'h69766F6D;
    localparam logic [31:0] FCC_00DB = 32'h62643030;
    localparam logic [31:0] FCC_IDX1 = 32'h31786469;
    localparam logic [31:0] USEC_PER_SEC = 32'd1000000;
    localparam int          HDR_WORDS = 60;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  cnt;
        logic        last;
        logic        err;
    } t_res;

endpackage

/* rtl/amux_ram.sv */
// ----------------------------------------------------------------------------
// amux_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module amux_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/amux_hdr.sv */
// ----------------------------------------------------------------------------
// amux_hdr
// Header word generator: selects one of the 60 AVI header words by position.
// ----------------------------------------------------------------------------
module amux_hdr (
    input  logic [5:0]  i_pos,
    input  logic [15:0] i_width,
    input  logic [15:0] i_height,
    input  logic [9:0]  i_fps,
    input  logic [12:0] i_total,
    input  logic [31:0] i_usec,
    input  logic [31:0] i_img,
    output logic [31:0] o_word
);
    logic [31:0] n32;

    assign n32 = {19'd0, i_total};

    always_comb begin
        case (i_pos)
            6'd0:  o_word = amux_pkg::FCC_RIFF;
            6'd1:  o_word = 32'd170 + (n32 * 32'd24);
            6'd2:  o_word = amux_pkg::FCC_AVI;
            6'd3:  o_word = amux_pkg::FCC_LIST;
            6'd4:  o_word = 32'd208;
            6'd5:  o_word = amux_pkg::FCC_HDRL;
            6'd6:  o_word = amux_pkg::FCC_AVIH;
            6'd7:  o_word = 32'd56;
            6'd8:  o_word = i_usec;
            6'd9:  o_word = 32'd7000;
            6'd11: o_word = 32'd16;
            6'd12: o_word = n32;
            6'd14: o_word = 32'd1;
            6'd16: o_word = {16'd0, i_width};
            6'd17: o_word = {16'd0, i_height};
            6'd22: o_word = amux_pkg::FCC_LIST;
            6'd23: o_word = 32'd132;
            6'd24: o_word = amux_pkg::FCC_STRL;
            6'd25: o_word = amux_pkg::FCC_STRH;
            6'd26: o_word = 32'd48;
            6'd27: o_word = amux_pkg::FCC_VIDS;
            6'd28: o_word = amux_pkg::FCC_MJPG;
            6'd32: o_word = 32'd1;
            6'd33: o_word = {22'd0, i_fps};
            6'd35: o_word = n32;
            6'd39: o_word = amux_pkg::FCC_STRF;
            6'd40: o_word = 32'd40;
            6'd41: o_word = 32'd40;
            6'd42: o_word = {16'd0, i_width};
            6'd43: o_word = {16'd0, i_height};
            6'd44: o_word = 32'h00180001;
            6'd45: o_word = amux_pkg::FCC_MJPG;
            6'd46: o_word = i_img;
            6'd51: o_word = amux_pkg::FCC_LIST;
            6'd52: o_word = 32'd16;
            6'd53: o_word = amux_pkg::FCC_ODML;
            6'd54: o_word = amux_pkg::FCC_DMLH;
            6'd55: o_word = 32'd4;
            6'd56: o_word = n32;
            6'd57: o_word = amux_pkg::FCC_LIST;
            6'd58: o_word = 32'd4 + (n32 << 3);
            6'd59: o_word = amux_pkg::FCC_MOVI;
            default: o_word = 32'd0;
        endcase
    end
endmodule

/* rtl/avi_mjpeg_muxer_top.sv */
// ----------------------------------------------------------------------------
// avi_mjpeg_muxer_top
// AVI RIFF container muxer for MJPEG frames, 32-bit little-endian output.
// ----------------------------------------------------------------------------
// Items enter on the s_axis channel (tuser = mode, tdata = data_byte and
// frame_length) and results leave on m_axis (tdata = word and byte count,
// tuser = error, tlast = final result of an item). Registers are written on
// the cfg channel; the user must write them only while the block is idle,
// which the block itself does not enforce. A frame byte may follow back to
// back while the output register is free, so payload streams at one byte per
// cycle. A start item first runs a restoring division for microseconds per
// frame, then emits 60 header words at one per cycle while the output
// register is free. Frame and index begin emit two words; an index entry
// first reads both index memories and then emits four words. The two index
// tables live in synchronous RAMs of INDEX_DEPTH entries with registered
// read data. After reset the block is idle with default registers and takes
// items at once. When the receiver stalls, the output register holds its
// result and no further item or result is taken until it drains.
// ----------------------------------------------------------------------------
module avi_mjpeg_muxer_top #(
    parameter int INDEX_DEPTH = 4096,
    parameter int LENGTH_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [LENGTH_BITS+7:0] s_axis_tdata,  // data_byte, frame_length
    input  logic [2:0]             s_axis_tuser,  // mode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [39:0]            m_axis_tdata,  // out_word, byte_count, zeros
    output logic                   m_axis_tuser,  // error
    output logic                   m_axis_tlast,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [2:0]             i_cfg_index,
    input  logic [31:0]            i_cfg_data
);
    localparam int AW  = (INDEX_DEPTH > 1) ? $clog2(INDEX_DEPTH) : 1;
    localparam int CW  = $clog2(INDEX_DEPTH + 1);
    localparam int LB  = LENGTH_BITS;

    logic [15:0] r_width, r_height;
    logic [9:0]  r_fps;
    logic [12:0] r_total;
    logic [31:0] r_first;

    amux_pkg::t_phase r_phase, n_phase;
    amux_pkg::t_state r_state, n_state;
    logic [31:0] r_offset, n_offset;
    logic [LB-1:0] r_left, n_left;
    logic        r_odd, n_odd;
    logic [CW-1:0] r_frames, n_frames;
    logic [CW-1:0] r_iptr, n_iptr;
    logic [5:0]  r_pos, n_pos;
    logic [1:0]  r_seq, n_seq;
    logic [31:0] r_w1, n_w1;
    logic [31:0] r_pad, n_pad;
    logic        r_ovalid, n_ovalid;
    amux_pkg::t_res r_out, n_out;
    logic [31:0] r_usec, n_usec;
    logic [19:0] r_rem, n_rem;
    logic [4:0]  r_dcnt, n_dcnt;
    logic [31:0] r_img;

    logic        in_acc, out_free;
    logic [2:0]  in_mode;
    logic [7:0]  in_byte;
    logic [LB-1:0] in_len;
    logic        we;
    logic [LB-1:0] len_rd;
    logic [31:0] off_rd, len_pad, hdr_word;
    logic [20:0] rem_try;

    assign in_mode = s_axis_tuser;
    assign in_byte = s_axis_tdata[7:0];
    assign in_len  = s_axis_tdata[LB+7:8];
    assign out_free = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == amux_pkg::ST_IDLE) && out_free;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_out.cnt, r_out.word};
    assign m_axis_tuser  = r_out.err;
    assign m_axis_tlast  = r_out.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 16'd640;
            r_height <= 16'd480;
            r_fps    <= 10'd30;
            r_total  <= 13'd0;
            r_first  <= 32'd4;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                amux_pkg::REG_WIDTH:  r_width  <= i_cfg_data[15:0];
                amux_pkg::REG_HEIGHT: r_height <= i_cfg_data[15:0];
                amux_pkg::REG_FPS:    r_fps    <= i_cfg_data[9:0];
                amux_pkg::REG_TOTAL:  r_total  <= i_cfg_data[12:0];
                amux_pkg::REG_FIRST:  r_first  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_img <= (({16'd0, r_width} * 32'd3 + 32'd3) & 32'hFFFFFFFC) * {16'd0, r_height};
    end

    assign we = in_acc && (in_mode == amux_pkg::MODE_FBEGIN) && (r_phase == amux_pkg::PH_MOVI)
                && (r_frames < CW'(INDEX_DEPTH));

    amux_ram #(.WIDTH(LB), .DEPTH(INDEX_DEPTH)) u_len_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_frames[AW-1:0]), .i_wdata(in_len),
        .i_raddr(r_iptr[AW-1:0]), .o_rdata(len_rd)
    );
    amux_ram #(.WIDTH(32), .DEPTH(INDEX_DEPTH)) u_off_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(r_frames[AW-1:0]), .i_wdata(r_offset),
        .i_raddr(r_iptr[AW-1:0]), .o_rdata(off_rd)
    );

    amux_hdr u_hdr (
        .i_pos(r_pos), .i_width(r_width), .i_height(r_height), .i_fps(r_fps),
        .i_total(r_total), .i_usec(r_usec), .i_img(r_img), .o_word(hdr_word)
    );

    assign len_pad = 32'(len_rd) + {31'd0, len_rd[0]};
    assign rem_try = {r_rem, amux_pkg::USEC_PER_SEC[5'd19 - r_dcnt]} - {11'd0, r_fps};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= amux_pkg::PH_IDLE;
            r_state  <= amux_pkg::ST_IDLE;
            r_offset <= 32'd0;
            r_left   <= '0;
            r_odd    <= 1'b0;
            r_frames <= '0;
            r_iptr   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_state  <= n_state;
            r_offset <= n_offset;
            r_left   <= n_left;
            r_odd    <= n_odd;
            r_frames <= n_frames;
            r_iptr   <= n_iptr;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_seq  <= n_seq;
        r_w1   <= n_w1;
        r_pad  <= n_pad;
        r_out  <= n_out;
        r_usec <= n_usec;
        r_rem  <= n_rem;
        r_dcnt <= n_dcnt;
    end

    always_comb begin
        n_phase  = r_phase;
        n_state  = r_state;
        n_offset = r_offset;
        n_left   = r_left;
        n_odd    = r_odd;
        n_frames = r_frames;
        n_iptr   = r_iptr;
        n_pos    = r_pos;
        n_seq    = r_seq;
        n_w1     = r_w1;
        n_pad    = r_pad;
        n_usec   = r_usec;
        n_rem    = r_rem;
        n_dcnt   = r_dcnt;
        n_out    = r_out;
        n_ovalid = r_ovalid && !m_axis_tready;
        unique case (r_state)
            amux_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_ovalid = 1'b1;
                    n_out = '{word: 32'd0, cnt: 3'd0, last: 1'b1, err: 1'b1};
                    case (in_mode)
                        amux_pkg::MODE_START: begin
                            if (r_phase == amux_pkg::PH_IDLE || r_phase == amux_pkg::PH_INDEX) begin
                                n_ovalid = 1'b0;
                                n_offset = r_first;
                                n_frames = '0;
                                n_iptr   = '0;
                                n_left   = '0;
                                n_odd    = 1'b0;
                                n_phase  = amux_pkg::PH_MOVI;
                                n_usec   = 32'd0;
                                n_rem    = 20'd0;
                                n_dcnt   = 5'd0;
                                n_pos    = 6'd0;
                                n_state  = amux_pkg::ST_DIV;
                            end
                        end
                        amux_pkg::MODE_FBEGIN: begin
                            if (we) begin
                                n_offset = r_offset + 32'(in_len) + {31'd0, in_len[0]} + 32'd8;
                                n_frames = r_frames + 1'b1;
                                n_left   = in_len;
                                n_odd    = in_len[0];
                                n_phase  = (in_len != '0) ? amux_pkg::PH_FRAME : amux_pkg::PH_MOVI;
                                n_out    = '{word: amux_pkg::FCC_00DB, cnt: 3'd4, last: 1'b0, err: 1'b0};
                                n_w1     = 32'(in_len);
                                n_seq    = 2'd1;
                                n_state  = amux_pkg::ST_SEQ;
                            end
                        end
                        amux_pkg::MODE_FBYTE: begin
                            if (r_phase == amux_pkg::PH_FRAME && r_left != '0) begin
                                n_left = r_left - 1'b1;
                                n_out  = '{word: {24'd0, in_byte}, cnt: 3'd1, last: 1'b1, err: 1'b0};
                                if (r_left == LB'(1)) begin
                                    n_phase = amux_pkg::PH_MOVI;
                                    if (r_odd) n_out.cnt = 3'd2;
                                end
                            end
                        end
                        amux_pkg::MODE_IBEGIN: begin
                            if (r_phase == amux_pkg::PH_MOVI) begin
                                n_phase = amux_pkg::PH_INDEX;
                                n_iptr  = '0;
                                n_out   = '{word: amux_pkg::FCC_IDX1, cnt: 3'd4, last: 1'b0, err: 1'b0};
                                n_w1    = {15'd0, r_total, 4'd0};
                                n_seq   = 2'd1;
                                n_state = amux_pkg::ST_SEQ;
                            end
                        end
                        amux_pkg::MODE_INEXT: begin
                            if (r_phase == amux_pkg::PH_INDEX && r_iptr < CW'(INDEX_DEPTH)
                                && 32'(r_iptr) < {19'd0, r_total}) begin
                                n_ovalid = 1'b0;
                                n_state  = amux_pkg::ST_IDXRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            amux_pkg::ST_DIV: begin
                if (rem_try[20] == 1'b0) begin
                    n_rem = rem_try[19:0];
                    n_usec = {r_usec[30:0], 1'b1};
                end else begin
                    n_rem = {r_rem[18:0], amux_pkg::USEC_PER_SEC[5'd19 - r_dcnt]};
                    n_usec = {r_usec[30:0], 1'b0};
                end
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == 5'd19) begin
                    if (r_fps == 10'd0) n_usec = 32'd0;
                    n_state = amux_pkg::ST_HDR;
                end
            end
            amux_pkg::ST_HDR: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_out = '{word: hdr_word, cnt: 3'd4,
                              last: (r_pos == 6'(amux_pkg::HDR_WORDS - 1)), err: 1'b0};
                    n_pos = r_pos + 1'b1;
                    if (r_pos == 6'(amux_pkg::HDR_WORDS - 1)) n_state = amux_pkg::ST_IDLE;
                end
            end
            amux_pkg::ST_IDXRD: begin
                n_ovalid = 1'b1;
                n_out = '{word: amux_pkg::FCC_00DB, cnt: 3'd4, last: 1'b0, err: 1'b0};
                n_w1  = 32'd16;
                n_seq = 2'd1;
                n_iptr = r_iptr + 1'b1;
                n_usec = off_rd;
                n_pad  = len_pad;
                n_rem  = 20'd0;
                n_state = amux_pkg::ST_SEQ;
            end
            amux_pkg::ST_SEQ: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_seq = r_seq + 1'b1;
                    n_out = '{word: r_w1, cnt: 3'd4, last: 1'b0, err: 1'b0};
                    if (r_seq == 2'd1) begin
                        n_w1 = r_usec;
                        if (r_phase != amux_pkg::PH_INDEX || r_w1 != 32'd16 || r_iptr == '0
                            || r_out.word != amux_pkg::FCC_00DB) begin
                            n_out.last = 1'b1;
                            n_state = amux_pkg::ST_IDLE;
                        end
                    end else if (r_seq == 2'd2) begin
                        n_w1 = r_pad;
                    end else begin
                        n_out.last = 1'b1;
                        n_state = amux_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = amux_pkg::ST_IDLE;
        endcase
    end
endmodule
